// ----- sv/sem_pkg.sv -----
// Shared constants, types and command structs of the Sobel edge magnitude block.
`default_nettype none
package sem_pkg;

   // Frame limits and the fixed field widths.
   localparam int MAX_WIDTH  = 2048;
   localparam int MAX_HEIGHT = 4096;
   localparam int COL_W      = $clog2(MAX_WIDTH);
   localparam int ROW_W      = $clog2(MAX_HEIGHT);
   localparam int PIX_W      = 8;
   localparam int MAG_W      = 8;

   // Configuration registers.
   localparam int WREG_W       = 12;
   localparam int HREG_W       = 13;
   localparam int WIDTH_RESET  = 640;
   localparam int HEIGHT_RESET = 480;
   localparam int MIN_SIZE     = 3;
   localparam int CSR_DATA_W   = 32;
   localparam int CSR_ADDR_W   = 3;
   localparam logic REG_IMAGE_WIDTH  = 1'b0;
   localparam logic REG_IMAGE_HEIGHT = 1'b1;

   // Widths of the clamped sizes: wide enough for the register and the limit.
   localparam int WEFF_W = (WREG_W > COL_W + 1) ? WREG_W : COL_W + 1;
   localparam int HEFF_W = (HREG_W > ROW_W + 1) ? HREG_W : ROW_W + 1;

   // Gradient and root arithmetic.
   localparam int GRAD_W     = 11;
   localparam int SQ_W       = 20;
   localparam int SUM_W      = 21;
   localparam int ROOT_OPND_W = 16;
   localparam int ROOT_ACC_W  = 17;
   localparam int ROOT_STEPS  = ROOT_OPND_W / 2;
   localparam int ITER_W      = $clog2(ROOT_STEPS);

   typedef struct packed {
      logic [WREG_W-1:0] image_width;
      logic [HREG_W-1:0] image_height;
   } cfg_type;

   typedef struct packed {
      logic accept;
      logic write_line;
      logic grad;
      logic square;
      logic sum_init;
      logic root_step;
      logic load_out;
   } cmd_type;

   typedef struct packed {
      logic interior;
   } stat_type;

endpackage
`default_nettype wire

// ----- sv/sem_req_if.sv -----
// Pixel input channel: valid, ready and the pixel payload.
`default_nettype none
interface sem_req_if;
   logic                     valid;
   logic                     ready;
   logic [sem_pkg::PIX_W-1:0] pixel;
   logic                     frame_start;

   modport source (output valid, output pixel, output frame_start, input ready);
   modport sink   (input valid, input pixel, input frame_start, output ready);
endinterface
`default_nettype wire

// ----- sv/sem_rsp_if.sv -----
// Result channel: valid, ready and the edge magnitude payload.
`default_nettype none
interface sem_rsp_if;
   logic                     valid;
   logic                     ready;
   logic [sem_pkg::MAG_W-1:0] edge_magnitude;
   logic [sem_pkg::ROW_W-1:0] center_row;
   logic [sem_pkg::COL_W-1:0] center_column;
   logic                     frame_last;

   modport source (output valid, output edge_magnitude, output center_row,
                   output center_column, output frame_last, input ready);
   modport sink   (input valid, input edge_magnitude, input center_row,
                   input center_column, input frame_last, output ready);
endinterface
`default_nettype wire

// ----- sv/sem_csr.sv -----
// APB-style register file holding the frame width and height.
`default_nettype none
module sem_csr (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           csr_psel,
   input  wire logic                           csr_penable,
   input  wire logic                           csr_pwrite,
   input  wire logic [sem_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  wire logic [sem_pkg::CSR_DATA_W-1:0] csr_pwdata,
   output logic      [sem_pkg::CSR_DATA_W-1:0] csr_prdata,
   output logic                                csr_pready,
   output sem_pkg::cfg_type                    cfg
);

   logic [sem_pkg::WREG_W-1:0] width_ff;
   logic [sem_pkg::HREG_W-1:0] height_ff;
   logic                       wr_en;
   logic                       reg_sel;

   assign csr_pready = 1'b1;
   assign wr_en      = csr_psel && csr_penable && csr_pwrite;
   // Word address picks the register.
   assign reg_sel    = csr_paddr[2];

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= sem_pkg::WREG_W'(sem_pkg::WIDTH_RESET);
         height_ff <= sem_pkg::HREG_W'(sem_pkg::HEIGHT_RESET);
      end else if (wr_en) begin
         if (reg_sel == sem_pkg::REG_IMAGE_WIDTH) begin
            width_ff <= csr_pwdata[sem_pkg::WREG_W-1:0];
         end else begin
            height_ff <= csr_pwdata[sem_pkg::HREG_W-1:0];
         end
      end
   end

   always_comb begin
      unique case (reg_sel)
         sem_pkg::REG_IMAGE_WIDTH:  csr_prdata = sem_pkg::CSR_DATA_W'(width_ff);
         sem_pkg::REG_IMAGE_HEIGHT: csr_prdata = sem_pkg::CSR_DATA_W'(height_ff);
         default:                   csr_prdata = '0;
      endcase
   end

   assign cfg.image_width  = width_ff;
   assign cfg.image_height = height_ff;

endmodule
`default_nettype wire

// ----- sv/sem_ctrl.sv -----
// Controller: sequences one pixel through line store, gradient, square and root steps.
`default_nettype none
module sem_ctrl (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_ready,
   output logic                   rsp_valid,
   input  wire logic              rsp_ready,
   input  wire sem_pkg::stat_type stat,
   output sem_pkg::cmd_type       cmd
);

   typedef enum logic [2:0] {
      S_IDLE,
      S_WRITE,
      S_GRAD,
      S_SQUARE,
      S_SUM,
      S_ROOT,
      S_EMIT
   } state_type;

   state_type                  state_ff, state_in;
   logic [sem_pkg::ITER_W-1:0] iter_ff, iter_in;
   logic                       out_valid_ff, out_valid_in;
   logic                       accept;
   logic                       out_free;
   logic                       root_last;

   assign req_ready = (state_ff == S_IDLE);
   assign accept    = req_valid && req_ready;
   assign out_free  = !out_valid_ff || rsp_ready;
   assign root_last = (iter_ff == sem_pkg::ITER_W'(sem_pkg::ROOT_STEPS - 1));
   assign rsp_valid = out_valid_ff;

   always_comb begin
      cmd            = '0;
      cmd.accept     = accept;
      cmd.write_line = (state_ff == S_WRITE);
      cmd.grad       = (state_ff == S_GRAD);
      cmd.square     = (state_ff == S_SQUARE);
      cmd.sum_init   = (state_ff == S_SUM);
      cmd.root_step  = (state_ff == S_ROOT);
      cmd.load_out   = (state_ff == S_EMIT) && out_free;
   end

   always_comb begin
      state_in     = state_ff;
      iter_in      = iter_ff;
      out_valid_in = out_valid_ff && !rsp_ready;
      unique case (state_ff)
         S_IDLE: begin
            if (accept) state_in = S_WRITE;
         end
         S_WRITE: begin
            // Border pixels only update the stores and window.
            state_in = stat.interior ? S_GRAD : S_IDLE;
         end
         S_GRAD:   state_in = S_SQUARE;
         S_SQUARE: state_in = S_SUM;
         S_SUM: begin
            iter_in  = '0;
            state_in = S_ROOT;
         end
         S_ROOT: begin
            iter_in = iter_ff + 1'b1;
            if (root_last) state_in = S_EMIT;
         end
         S_EMIT: begin
            // Hold until the output register is free.
            if (out_free) begin
               out_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         iter_ff      <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         iter_ff      <= iter_in;
         out_valid_ff <= out_valid_in;
      end
   end

   a_accept_to_write: assert property (@(posedge clock) disable iff (reset)
      accept |=> state_ff == S_WRITE)
      else $error("accepted item did not move to line store write");

   a_root_length: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_ROOT && root_last) |=> state_ff == S_EMIT)
      else $error("root did not finish after its last step");

   a_valid_from_emit: assert property (@(posedge clock) disable iff (reset)
      $rose(out_valid_ff) |-> $past(state_ff) == S_EMIT)
      else $error("result raised outside the emit step");

   a_border_no_result: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_WRITE && !stat.interior) |=> state_ff == S_IDLE)
      else $error("border pixel went on to the gradient steps");

endmodule
`default_nettype wire

// ----- sv/sem_datapath.sv -----
// Datapath: counters, line stores, 3x3 window, gradients, squares and the iterative root.
`default_nettype none
module sem_datapath (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire sem_pkg::cfg_type          cfg,
   input  wire sem_pkg::cmd_type          cmd,
   output sem_pkg::stat_type              stat,
   input  wire logic [sem_pkg::PIX_W-1:0] req_pixel,
   input  wire logic                      req_frame_start,
   output logic      [sem_pkg::MAG_W-1:0] rsp_edge_magnitude,
   output logic      [sem_pkg::ROW_W-1:0] rsp_center_row,
   output logic      [sem_pkg::COL_W-1:0] rsp_center_column,
   output logic                           rsp_frame_last
);

   localparam int COL_W = sem_pkg::COL_W;
   localparam int ROW_W = sem_pkg::ROW_W;
   localparam int PIX_W = sem_pkg::PIX_W;
   localparam int WEFF_W = sem_pkg::WEFF_W;
   localparam int HEFF_W = sem_pkg::HEFF_W;
   localparam int GRAD_W = sem_pkg::GRAD_W;
   localparam int SQ_W = sem_pkg::SQ_W;
   localparam int SUM_W = sem_pkg::SUM_W;
   localparam int OPND_W = sem_pkg::ROOT_OPND_W;
   localparam int ACC_W = sem_pkg::ROOT_ACC_W;

   // Clamped frame size.
   logic [WEFF_W-1:0] w_reg, w_eff;
   logic [HEFF_W-1:0] h_reg, h_eff;

   assign w_reg = WEFF_W'(cfg.image_width);
   assign h_reg = HEFF_W'(cfg.image_height);

   always_comb begin
      priority if (w_reg < WEFF_W'(sem_pkg::MIN_SIZE)) w_eff = WEFF_W'(sem_pkg::MIN_SIZE);
      else if (w_reg > WEFF_W'(sem_pkg::MAX_WIDTH))    w_eff = WEFF_W'(sem_pkg::MAX_WIDTH);
      else                                             w_eff = w_reg;
      priority if (h_reg < HEFF_W'(sem_pkg::MIN_SIZE)) h_eff = HEFF_W'(sem_pkg::MIN_SIZE);
      else if (h_reg > HEFF_W'(sem_pkg::MAX_HEIGHT))   h_eff = HEFF_W'(sem_pkg::MAX_HEIGHT);
      else                                             h_eff = h_reg;
   end

   // Raster counters, advanced when an item is accepted.
   logic [COL_W-1:0] col_count_ff, col_count_in, col_eff;
   logic [ROW_W-1:0] row_count_ff, row_count_in, row_eff;
   logic [COL_W:0]   col_inc;
   logic [ROW_W:0]   row_inc;
   logic             col_wrap, row_wrap, row_over;

   assign col_eff  = req_frame_start ? '0 : col_count_ff;
   assign row_eff  = req_frame_start ? '0 : row_count_ff;
   assign col_inc  = {1'b0, col_eff} + 1'b1;
   assign row_inc  = {1'b0, row_eff} + 1'b1;
   assign col_wrap = WEFF_W'(col_inc) >= w_eff;
   assign row_wrap = HEFF_W'(row_inc) >= h_eff;
   assign row_over = HEFF_W'(row_eff) >= h_eff;

   always_comb begin
      col_count_in = col_count_ff;
      row_count_in = row_count_ff;
      if (cmd.accept) begin
         if (col_wrap) begin
            col_count_in = '0;
            row_count_in = row_wrap ? '0 : row_inc[ROW_W-1:0];
         end else begin
            col_count_in = col_inc[COL_W-1:0];
            row_count_in = row_over ? '0 : row_eff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_count_ff <= '0;
         row_count_ff <= '0;
      end else begin
         col_count_ff <= col_count_in;
         row_count_ff <= row_count_in;
      end
   end

   // Per-item registers captured at accept.
   logic [PIX_W-1:0] pix_ff;
   logic [COL_W-1:0] col_cur_ff, center_col_ff;
   logic [ROW_W-1:0] center_row_ff;
   logic             last_ff;
   logic             interior_ff;

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         pix_ff        <= req_pixel;
         col_cur_ff    <= col_eff;
         center_col_ff <= col_eff - 1'b1;
         center_row_ff <= row_eff - 1'b1;
         last_ff       <= row_wrap && col_wrap;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         interior_ff <= 1'b0;
      end else if (cmd.accept) begin
         interior_ff <= (row_eff >= ROW_W'(2)) && (col_eff >= COL_W'(2));
      end
   end

   assign stat.interior = interior_ff;

   // Line stores: read at accept, written in the cycle after it.
   logic [PIX_W-1:0] upper_mem  [sem_pkg::MAX_WIDTH];
   logic [PIX_W-1:0] middle_mem [sem_pkg::MAX_WIDTH];
   logic [PIX_W-1:0] up_rd_ff, mid_rd_ff;

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         up_rd_ff  <= upper_mem[col_eff];
         mid_rd_ff <= middle_mem[col_eff];
      end
      if (cmd.write_line) begin
         upper_mem[col_cur_ff]  <= mid_rd_ff;
         middle_mem[col_cur_ff] <= pix_ff;
      end
   end

   // 3x3 window, newest column at index 2.
   logic [PIX_W-1:0] win_ff [3][3];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int r = 0; r < 3; r++) begin
            for (int c = 0; c < 3; c++) begin
               win_ff[r][c] <= '0;
            end
         end
      end else if (cmd.write_line) begin
         for (int r = 0; r < 3; r++) begin
            win_ff[r][0] <= win_ff[r][1];
            win_ff[r][1] <= win_ff[r][2];
         end
         win_ff[0][2] <= up_rd_ff;
         win_ff[1][2] <= mid_rd_ff;
         win_ff[2][2] <= pix_ff;
      end
   end

   // Gradients.
   logic [GRAD_W-1:0]        gx_pos, gx_neg, gy_pos, gy_neg;
   logic signed [GRAD_W-1:0] gx_ff, gy_ff;

   assign gx_pos = GRAD_W'(win_ff[0][2]) + (GRAD_W'(win_ff[1][2]) << 1) + GRAD_W'(win_ff[2][2]);
   assign gx_neg = GRAD_W'(win_ff[0][0]) + (GRAD_W'(win_ff[1][0]) << 1) + GRAD_W'(win_ff[2][0]);
   assign gy_pos = GRAD_W'(win_ff[2][0]) + (GRAD_W'(win_ff[2][1]) << 1) + GRAD_W'(win_ff[2][2]);
   assign gy_neg = GRAD_W'(win_ff[0][0]) + (GRAD_W'(win_ff[0][1]) << 1) + GRAD_W'(win_ff[0][2]);

   always_ff @(posedge clock) begin
      if (cmd.grad) begin
         gx_ff <= signed'(gx_pos - gx_neg);
         gy_ff <= signed'(gy_pos - gy_neg);
      end
   end

   // Squares, one multiplier each, registered.
   logic signed [2*GRAD_W-1:0] gx_prod, gy_prod;
   logic [SQ_W-1:0]            gx_sq_ff, gy_sq_ff;

   assign gx_prod = gx_ff * gx_ff;
   assign gy_prod = gy_ff * gy_ff;

   always_ff @(posedge clock) begin
      if (cmd.square) begin
         gx_sq_ff <= gx_prod[SQ_W-1:0];
         gy_sq_ff <= gy_prod[SQ_W-1:0];
      end
   end

   // Sum, saturation check and digit-pair root.
   logic [SUM_W-1:0]  sum;
   logic              sat_ff;
   logic [OPND_W-1:0] rem_ff;
   logic [ACC_W-1:0]  res_ff;
   logic [OPND_W-1:0] bit_ff;
   logic [ACC_W-1:0]  trial;

   assign sum   = SUM_W'(gx_sq_ff) + SUM_W'(gy_sq_ff);
   assign trial = res_ff + ACC_W'(bit_ff);

   always_ff @(posedge clock) begin
      if (cmd.sum_init) begin
         sat_ff <= (sum[SUM_W-1:OPND_W] != '0);
         rem_ff <= sum[OPND_W-1:0];
         res_ff <= '0;
         bit_ff <= OPND_W'(1) << (OPND_W - 2);
      end else if (cmd.root_step) begin
         if (ACC_W'(rem_ff) >= trial) begin
            rem_ff <= rem_ff - trial[OPND_W-1:0];
            res_ff <= (res_ff >> 1) + ACC_W'(bit_ff);
         end else begin
            res_ff <= res_ff >> 1;
         end
         bit_ff <= bit_ff >> 2;
      end
   end

   // Output register.
   always_ff @(posedge clock) begin
      if (cmd.load_out) begin
         rsp_edge_magnitude <= sat_ff ? '1 : res_ff[sem_pkg::MAG_W-1:0];
         rsp_center_row     <= center_row_ff;
         rsp_center_column  <= center_col_ff;
         rsp_frame_last     <= last_ff;
      end
   end

   a_root_fits: assert property (@(posedge clock) disable iff (reset)
      (cmd.load_out && !sat_ff) |-> res_ff[ACC_W-1:sem_pkg::MAG_W] == '0)
      else $error("root result exceeds the magnitude width");

   a_window_takes_pixel: assert property (@(posedge clock) disable iff (reset)
      cmd.write_line |=> win_ff[2][2] == $past(pix_ff))
      else $error("window did not take the current pixel");

   a_frame_start_counts: assert property (@(posedge clock) disable iff (reset)
      (cmd.accept && req_frame_start) |=> (col_count_ff == COL_W'(1) && row_count_ff == '0))
      else $error("frame start did not restart the counters");

endmodule
`default_nettype wire

// ----- sv/sobel_edge_magnitude.sv -----
// Sobel 3x3 gradient magnitude: top level joining registers, controller and datapath.
// A result is valid once its pixel has passed the emit step, if the output is free.
// One item at a time; a border pixel ends after its line store write, an interior pixel
// runs the 8-step root unit following the line store, gradient, square and sum steps.
// A finished result waits in the output register while the next pixel is taken.
// Reset (synchronous, active high) clears counters, window, control state and sets
// width 640 and height 480; line stores have no reset and need no clearing pass.
`default_nettype none
module sobel_edge_magnitude (
   input  wire logic                           clock,
   input  wire logic                           reset,
   sem_req_if.sink                             req_chan,
   sem_rsp_if.source                           rsp_chan,
   input  wire logic                           csr_psel,
   input  wire logic                           csr_penable,
   input  wire logic                           csr_pwrite,
   input  wire logic [sem_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  wire logic [sem_pkg::CSR_DATA_W-1:0] csr_pwdata,
   output logic      [sem_pkg::CSR_DATA_W-1:0] csr_prdata,
   output logic                                csr_pready
);

   sem_pkg::cfg_type  cfg;
   sem_pkg::cmd_type  cmd;
   sem_pkg::stat_type stat;

   sem_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   sem_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .rsp_valid (rsp_chan.valid),
      .rsp_ready (rsp_chan.ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   sem_datapath u_datapath (
      .clock              (clock),
      .reset              (reset),
      .cfg                (cfg),
      .cmd                (cmd),
      .stat               (stat),
      .req_pixel          (req_chan.pixel),
      .req_frame_start    (req_chan.frame_start),
      .rsp_edge_magnitude (rsp_chan.edge_magnitude),
      .rsp_center_row     (rsp_chan.center_row),
      .rsp_center_column  (rsp_chan.center_column),
      .rsp_frame_last     (rsp_chan.frame_last)
   );

endmodule
`default_nettype wire
